### design/shell_command_lexer_top_macros.svh
// Assertion macros for the shell command lexer checks.
`ifndef SHELL_COMMAND_LEXER_TOP_MACROS_SVH
`define SHELL_COMMAND_LEXER_TOP_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define SCL_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("shell lexer check failed");

// Check that a condition implies another in the following cycle.
`define SCL_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("shell lexer check failed");

`endif

### design/scl_pkg.sv
// Shared types and constants for the shell command lexer.
package scl_pkg;

    // Character codes that the lexer treats specially
    localparam logic [7:0] CH_PIPE  = 8'h7C;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Token kind codes
    localparam logic [2:0] KIND_WORD    = 3'd0;
    localparam logic [2:0] KIND_PIPE    = 3'd1;
    localparam logic [2:0] KIND_IN      = 3'd2;
    localparam logic [2:0] KIND_OUT     = 3'd3;
    localparam logic [2:0] KIND_APPEND  = 3'd4;
    localparam logic [2:0] KIND_HEREDOC = 3'd5;

    // Depth of the result queue; the 2-bit count covers up to three entries
    localparam int QDEPTH = 3;

    // Input request: one command-line byte
    typedef struct packed {
        logic [7:0] in_byte;
        logic       line_last;
    } t_req;

    // Result: one token byte with its marks
    typedef struct packed {
        logic       tok_valid;
        logic [7:0] tok_char;
        logic       tok_first;
        logic       tok_last;
        logic [2:0] tok_kind;
        logic       quote_error;
        logic       line_done;
        logic       run_last;
    } t_res;

endpackage

### design/shell_command_lexer_top.sv
// Shell command lexer: splits a byte stream into tokens with first/last marks.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------
//   request | in        | i_valid / o_stall  | i_req (t_req: byte, line end)
//   result  | out       | o_valid / i_stall  | o_res (t_res: token byte)
//
// A byte is decoded against the lexer state in the cycle it is accepted, and
// its zero to two results are registered into a three-entry result queue
// whose head drives o_res. One result leaves per cycle while i_stall is low,
// so the rate is one byte per cycle while each byte gives at most one result;
// a line's last byte may give two. o_stall is high while two or more results
// are queued. Reset is synchronous and clears the lexer state and queue count.
`include "shell_command_lexer_top_macros.svh"

module shell_command_lexer_top
    import scl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_res o_res
);

    typedef enum logic [3:0] {
        MODE_IDLE = 4'd0,
        MODE_WORD = 4'd1,
        MODE_SQ   = 4'd2,
        MODE_DQ   = 4'd3,
        MODE_LT1  = 4'd4,
        MODE_GT1  = 4'd5,
        MODE_LT2  = 4'd6,
        MODE_GT2  = 4'd7,
        MODE_PIPE = 4'd8
    } t_mode;

    t_mode      r_mode, n_mode;
    logic [7:0] r_held_char, n_held_char;
    logic       r_held_valid, n_held_valid;
    logic       r_held_first, n_held_first;

    t_res       r_q [QDEPTH];
    t_res       n_q [QDEPTH];
    logic [1:0] r_cnt, n_cnt;

    logic       acc;
    logic       pop;
    logic [1:0] base;

    // decode signals
    logic [7:0] c;
    logic       is_sp;
    logic       joined;
    t_mode      join_mode;
    t_mode      start_mode;
    logic [2:0] old_kind;
    logic [2:0] end_kind;
    logic       do_start;
    logic       qerr;
    t_mode      m_mode;
    logic [7:0] m_char;
    logic       m_valid;
    logic       m_first;
    t_res       res0, res1;
    logic [1:0] res_cnt;

    assign acc     = i_valid && !o_stall;
    assign pop     = (r_cnt != 2'd0) && !i_stall;
    assign o_valid = (r_cnt != 2'd0);
    assign o_stall = (r_cnt >= 2'd2);
    assign o_res   = r_q[0];
    assign base    = r_cnt - {1'b0, pop};

    assign c     = i_req.in_byte;
    assign is_sp = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));

    // Decide whether the byte joins the held token, and the mode it leads to
    always_comb begin
        joined    = 1'b0;
        join_mode = r_mode;
        unique case (r_mode)
            MODE_WORD: begin
                if (!(is_sp || c == CH_PIPE || c == CH_LT || c == CH_GT)) begin
                    joined = 1'b1;
                    if (c == CH_SQ) begin
                        join_mode = MODE_SQ;
                    end else if (c == CH_DQ) begin
                        join_mode = MODE_DQ;
                    end
                end
            end
            MODE_SQ: begin
                joined = 1'b1;
                if (c == CH_SQ) begin
                    join_mode = MODE_WORD;
                end
            end
            MODE_DQ: begin
                joined = 1'b1;
                if (c == CH_DQ) begin
                    join_mode = MODE_WORD;
                end
            end
            MODE_LT1: begin
                if (c == CH_LT) begin
                    joined    = 1'b1;
                    join_mode = MODE_LT2;
                end
            end
            MODE_GT1: begin
                if (c == CH_GT) begin
                    joined    = 1'b1;
                    join_mode = MODE_GT2;
                end
            end
            default: begin
                joined = 1'b0;
            end
        endcase
    end

    // Pick the mode a new token starts in
    always_comb begin
        priority if (is_sp) begin
            start_mode = MODE_IDLE;
        end else if (c == CH_PIPE) begin
            start_mode = MODE_PIPE;
        end else if (c == CH_LT) begin
            start_mode = MODE_LT1;
        end else if (c == CH_GT) begin
            start_mode = MODE_GT1;
        end else if (c == CH_SQ) begin
            start_mode = MODE_SQ;
        end else if (c == CH_DQ) begin
            start_mode = MODE_DQ;
        end else begin
            start_mode = MODE_WORD;
        end
    end

    // Map the closing mode to a token kind
    always_comb begin
        unique case (r_mode)
            MODE_PIPE: old_kind = KIND_PIPE;
            MODE_LT1:  old_kind = KIND_IN;
            MODE_GT1:  old_kind = KIND_OUT;
            MODE_LT2:  old_kind = KIND_HEREDOC;
            MODE_GT2:  old_kind = KIND_APPEND;
            default:   old_kind = KIND_WORD;
        endcase
        unique case (m_mode)
            MODE_PIPE: end_kind = KIND_PIPE;
            MODE_LT1:  end_kind = KIND_IN;
            MODE_GT1:  end_kind = KIND_OUT;
            MODE_LT2:  end_kind = KIND_HEREDOC;
            MODE_GT2:  end_kind = KIND_APPEND;
            default:   end_kind = KIND_WORD;
        endcase
    end

    // Emit the held byte, update the held token, and flush at line end
    always_comb begin
        res0     = '0;
        res1     = '0;
        res_cnt  = 2'd0;
        do_start = 1'b1;
        m_mode   = r_mode;
        m_char   = r_held_char;
        m_valid  = r_held_valid;
        m_first  = r_held_first;

        if (r_held_valid && r_mode != MODE_IDLE) begin
            res0.tok_valid = 1'b1;
            res0.tok_char  = r_held_char;
            res0.tok_first = r_held_first;
            res_cnt        = 2'd1;
            if (joined) begin
                do_start = 1'b0;
                m_mode   = join_mode;
                m_char   = c;
                m_first  = 1'b0;
            end else begin
                res0.tok_last = 1'b1;
                res0.tok_kind = old_kind;
            end
        end

        if (do_start) begin
            m_mode  = start_mode;
            m_valid = !is_sp;
            m_char  = is_sp ? 8'h00 : c;
            m_first = !is_sp;
        end

        qerr = (m_mode == MODE_SQ) || (m_mode == MODE_DQ);

        if (i_req.line_last) begin
            if (m_valid) begin
                if (res_cnt == 2'd0) begin
                    res0.tok_valid = 1'b1;
                    res0.tok_char  = m_char;
                    res0.tok_first = m_first;
                    res0.tok_last  = 1'b1;
                    res0.tok_kind  = end_kind;
                end else begin
                    res1.tok_valid = 1'b1;
                    res1.tok_char  = m_char;
                    res1.tok_first = m_first;
                    res1.tok_last  = 1'b1;
                    res1.tok_kind  = end_kind;
                end
                res_cnt = res_cnt + 2'd1;
            end
            // close the line with a single marker result when no token byte is emitted
            if (res_cnt == 2'd0) begin
                res_cnt = 2'd1;
            end
            if (res_cnt == 2'd1) begin
                res0.quote_error = qerr;
                res0.line_done   = 1'b1;
            end else begin
                res1.quote_error = qerr;
                res1.line_done   = 1'b1;
            end
        end

        // mark the final result of this byte
        if (res_cnt == 2'd1) begin
            res0.run_last = 1'b1;
        end else if (res_cnt == 2'd2) begin
            res1.run_last = 1'b1;
        end
    end

    // Next lexer state: back to idle after the line's last byte
    always_comb begin
        n_mode       = r_mode;
        n_held_char  = r_held_char;
        n_held_valid = r_held_valid;
        n_held_first = r_held_first;
        if (acc) begin
            if (i_req.line_last) begin
                n_mode       = MODE_IDLE;
                n_held_char  = 8'h00;
                n_held_valid = 1'b0;
                n_held_first = 1'b0;
            end else begin
                n_mode       = m_mode;
                n_held_char  = m_char;
                n_held_valid = m_valid;
                n_held_first = m_first;
            end
        end
    end

    // Advance the result queue and append new results behind the survivors
    always_comb begin
        n_q[0] = pop ? r_q[1] : r_q[0];
        n_q[1] = pop ? r_q[2] : r_q[1];
        n_q[2] = r_q[2];
        for (int i = 0; i < QDEPTH; i++) begin
            if (acc && (res_cnt != 2'd0) && (2'(i) == base)) begin
                n_q[i] = res0;
            end else if (acc && (res_cnt == 2'd2) && (2'(i) == base + 2'd1)) begin
                n_q[i] = res1;
            end
        end
        n_cnt = base + (acc ? res_cnt : 2'd0);
    end

    // Hold lexer state and the result queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_held_char  <= 8'h00;
            r_held_valid <= 1'b0;
            r_held_first <= 1'b0;
            r_cnt        <= 2'd0;
        end else begin
            r_mode       <= n_mode;
            r_held_char  <= n_held_char;
            r_held_valid <= n_held_valid;
            r_held_first <= n_held_first;
            r_cnt        <= n_cnt;
        end
        r_q <= n_q;
    end

    // Checks on line closing and result marks
    `SCL_ASSERT_NOW(a_done_is_run_last, o_valid && o_res.line_done, o_res.run_last)
    `SCL_ASSERT_NOW(a_empty_closes_line, o_valid && !o_res.tok_valid,
        o_res.line_done && o_res.run_last)
    `SCL_ASSERT_NOW(a_qerr_on_done, o_valid && o_res.quote_error, o_res.line_done)
    `SCL_ASSERT_NEXT(a_line_end_idles, acc && i_req.line_last,
        !r_held_valid && r_mode == MODE_IDLE && r_cnt != 2'd0)

endmodule

### bench/shell_command_lexer_checker.sv
// Checker for the shell command lexer: predicts token bytes and compares results.
module shell_command_lexer_checker
    import scl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  logic i_req_stall,
    input  t_req i_req,
    input  logic i_res_valid,
    input  logic i_res_stall,
    input  t_res i_res,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Lexer modes: what kind of token the held byte belongs to
    typedef enum logic [3:0] {
        LEX_IDLE,
        LEX_WORD,
        LEX_SQUOTE,
        LEX_DQUOTE,
        LEX_LT,
        LEX_GT,
        LEX_LTLT,
        LEX_GTGT,
        LEX_PIPE
    } t_lex_mode;

    t_lex_mode  mode;
    logic [7:0] held_char;
    logic       held_valid;
    logic       held_first;
    t_res       expected_tokens[$];

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [2:0] kind_of(input t_lex_mode m);
        case (m)
            LEX_PIPE: return KIND_PIPE;
            LEX_LT:   return KIND_IN;
            LEX_GT:   return KIND_OUT;
            LEX_LTLT: return KIND_HEREDOC;
            LEX_GTGT: return KIND_APPEND;
            default:  return KIND_WORD;
        endcase
    endfunction

    function automatic t_res token_byte(input logic [7:0] c, input logic first,
                                        input logic last, input logic [2:0] kind);
        t_res r;
        r = '0;
        r.tok_valid = 1'b1;
        r.tok_char  = c;
        r.tok_first = first;
        r.tok_last  = last;
        r.tok_kind  = kind;
        return r;
    endfunction

    function automatic string fmt_token(input t_res r);
        return $sformatf("valid=%b char=%h first=%b last=%b kind=%0d qerr=%b done=%b run=%b",
                         r.tok_valid, r.tok_char, r.tok_first, r.tok_last, r.tok_kind,
                         r.quote_error, r.line_done, r.run_last);
    endfunction

    // Decide whether byte c continues the token held in mode m
    function automatic logic extends_token(input t_lex_mode m, input logic [7:0] c,
                                           output t_lex_mode next);
        next = m;
        case (m)
            LEX_WORD: begin
                if (is_blank(c) || c == CH_PIPE || c == CH_LT || c == CH_GT)
                    return 1'b0;
                if (c == CH_SQ)
                    next = LEX_SQUOTE;
                else if (c == CH_DQ)
                    next = LEX_DQUOTE;
                return 1'b1;
            end
            LEX_SQUOTE: begin
                if (c == CH_SQ)
                    next = LEX_WORD;
                return 1'b1;
            end
            LEX_DQUOTE: begin
                if (c == CH_DQ)
                    next = LEX_WORD;
                return 1'b1;
            end
            LEX_LT: begin
                if (c == CH_LT) begin
                    next = LEX_LTLT;
                    return 1'b1;
                end
                return 1'b0;
            end
            LEX_GT: begin
                if (c == CH_GT) begin
                    next = LEX_GTGT;
                    return 1'b1;
                end
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic drop_held();
        mode       = LEX_IDLE;
        held_char  = '0;
        held_valid = 1'b0;
        held_first = 1'b0;
    endtask

    // Start a new token with byte c, or go idle on whitespace
    task automatic open_token(input logic [7:0] c);
        if (is_blank(c)) begin
            drop_held();
        end else begin
            if (c == CH_PIPE)
                mode = LEX_PIPE;
            else if (c == CH_LT)
                mode = LEX_LT;
            else if (c == CH_GT)
                mode = LEX_GT;
            else if (c == CH_SQ)
                mode = LEX_SQUOTE;
            else if (c == CH_DQ)
                mode = LEX_DQUOTE;
            else
                mode = LEX_WORD;
            held_char  = c;
            held_valid = 1'b1;
            held_first = 1'b1;
        end
    endtask

    // Advance the lexer by one request and queue the token bytes it releases
    task automatic lex_byte(input t_req r);
        t_res      tok[2];
        int        n;
        t_lex_mode next;
        logic      qerr;
        n = 0;
        if (held_valid && mode != LEX_IDLE) begin
            if (extends_token(mode, r.in_byte, next)) begin
                tok[n] = token_byte(held_char, held_first, 1'b0, KIND_WORD);
                n++;
                held_char  = r.in_byte;
                held_first = 1'b0;
                mode       = next;
            end else begin
                tok[n] = token_byte(held_char, held_first, 1'b1, kind_of(mode));
                n++;
                open_token(r.in_byte);
            end
        end else begin
            open_token(r.in_byte);
        end
        // Flush the held byte at end of line and close the line
        if (r.line_last) begin
            qerr = (mode == LEX_SQUOTE || mode == LEX_DQUOTE);
            if (held_valid) begin
                tok[n] = token_byte(held_char, held_first, 1'b1, kind_of(mode));
                n++;
            end
            if (n == 0) begin
                tok[n] = '0;
                n++;
            end
            tok[n-1].quote_error = qerr;
            tok[n-1].line_done   = 1'b1;
            drop_held();
        end
        if (n > 0)
            tok[n-1].run_last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_tokens.push_back(tok[i]);
    endtask

    // Compare results first, then predict from the request accepted at this edge
    always @(posedge i_clk) begin
        t_res exp_tok;
        if (!i_rst_n) begin
            drop_held();
            expected_tokens.delete();
            o_fail_count = 0;
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (expected_tokens.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: unexpected result %s", $realtime, fmt_token(i_res));
                    o_fail_count++;
                end else begin
                    exp_tok = expected_tokens.pop_front();
                    if (i_res.tok_valid !== exp_tok.tok_valid ||
                        i_res.tok_char !== exp_tok.tok_char ||
                        i_res.tok_first !== exp_tok.tok_first ||
                        i_res.tok_last !== exp_tok.tok_last ||
                        i_res.tok_kind !== exp_tok.tok_kind ||
                        i_res.quote_error !== exp_tok.quote_error ||
                        i_res.line_done !== exp_tok.line_done ||
                        i_res.run_last !== exp_tok.run_last) begin
                        if (o_fail_count < 10) begin
                            $display("%0t: token mismatch", $realtime);
                            $display("    expected %s", fmt_token(exp_tok));
                            $display("    actual   %s", fmt_token(i_res));
                        end
                        o_fail_count++;
                    end
                end
            end
            if (i_req_valid && !i_req_stall)
                lex_byte(i_req);
        end
        o_pending = expected_tokens.size();
    end

endmodule

### bench/shell_command_lexer_top_tb.sv
// Testbench top for the shell command lexer: stimulus, handshake idling and verdict.
module shell_command_lexer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import scl_pkg::*;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    t_req i_req   = '0;
    logic o_stall;
    logic o_valid;
    t_res o_res;

    int fail_count;
    int pending;
    int idle_pct   = 0;
    int stall_pct  = 0;
    int hold_start = 0;
    int hold_seen  = 0;
    int hold_left  = 0;
    int bytes_sent = 0;

    logic [7:0] line_buf[$];

    always #10 i_clk = ~i_clk;

    shell_command_lexer_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (o_res)
    );

    shell_command_lexer_checker lexer_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_stall  (o_stall),
        .i_req        (i_req),
        .i_res_valid  (o_valid),
        .i_res_stall  (i_stall),
        .i_res        (o_res),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Stall the result side: long hold-off on request, else random per cycle
    always @(negedge i_clk) begin
        if (hold_start != hold_seen) begin
            hold_seen = hold_start;
            hold_left = 80;
        end
        if (hold_left > 0) begin
            i_stall = 1'b1;
            hold_left--;
        end else begin
            i_stall = ($urandom_range(99) < stall_pct);
        end
    end

    // Offer one byte after random idle cycles and hold it until accepted
    task automatic send_byte(input logic [7:0] c, input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid           = 1'b1;
        i_req.in_byte     = c;
        i_req.line_last   = last;
        do
            @(posedge i_clk);
        while (o_stall);
        bytes_sent++;
    endtask

    task automatic send_line();
        for (int i = 0; i < line_buf.size(); i++)
            send_byte(line_buf[i], i == line_buf.size() - 1);
        line_buf.delete();
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
        send_line();
    endtask

    function automatic logic [7:0] blank_byte();
        logic [7:0] b;
        if ($urandom_range(1))
            b = CH_SPACE;
        else
            b = CH_TAB + 8'($urandom_range(4));
        return b;
    endfunction

    // Mostly lowercase letters, sometimes any byte at all
    function automatic logic [7:0] word_byte();
        logic [7:0] b;
        if ($urandom_range(4) == 0)
            b = 8'($urandom_range(255));
        else
            b = 8'h61 + 8'($urandom_range(25));
        return b;
    endfunction

    function automatic logic [7:0] quoted_byte();
        case ($urandom_range(5))
            0:       return blank_byte();
            1:       return CH_PIPE;
            2:       return ($urandom_range(1)) ? CH_LT : CH_GT;
            3:       return ($urandom_range(1)) ? CH_SQ : CH_DQ;
            default: return word_byte();
        endcase
    endfunction

    // Build a well-formed command line with random content, plus some noise
    task automatic build_line();
        int         n_tok;
        int         len;
        logic [7:0] q;
        if ($urandom_range(9) == 0)
            line_buf.push_back(blank_byte());
        n_tok = $urandom_range(1, 5);
        for (int t = 0; t < n_tok; t++) begin
            case ($urandom_range(7))
                0, 1, 2: begin
                    len = $urandom_range(1, 4);
                    repeat (len) line_buf.push_back(word_byte());
                end
                3: line_buf.push_back(CH_PIPE);
                4: begin
                    q   = ($urandom_range(1)) ? CH_LT : CH_GT;
                    len = $urandom_range(1, 3);
                    repeat (len) line_buf.push_back(q);
                end
                5, 6: begin
                    q = ($urandom_range(1)) ? CH_SQ : CH_DQ;
                    if ($urandom_range(1))
                        line_buf.push_back(word_byte());
                    line_buf.push_back(q);
                    len = $urandom_range(0, 4);
                    repeat (len) line_buf.push_back(quoted_byte());
                    if ($urandom_range(9) != 0)
                        line_buf.push_back(q);
                end
                default: begin
                    len = $urandom_range(1, 3);
                    repeat (len) line_buf.push_back(8'($urandom_range(255)));
                end
            endcase
            if (t < n_tok - 1 && $urandom_range(3) != 0)
                line_buf.push_back(blank_byte());
        end
        if ($urandom_range(4) == 0)
            line_buf.push_back(blank_byte());
    endtask

    // Hard stop in case the handshake hangs
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 84; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 84; end
                default: begin idle_pct = 35; stall_pct = 35; end
            endcase

            if (phase == 0) begin
                // Blank-only line, single byte, pipe, operator runs, trailing blank
                send_text(" ");
                send_text("x");
                send_text("a|b");
                send_text("<<<>>");
                send_text(">x ");
                // Open quotes at end of line, and a closed quote around an operator
                send_text("'a|");
                send_text("\"x");
                send_text("'>'");
                // Zero byte and top byte as word bytes, line ending in a tab
                line_buf = '{8'h00, 8'hFF, CH_TAB};
                send_line();
                // Hold off the result side while requests keep coming
                hold_start++;
            end

            while (bytes_sent < 25 + 131 * (phase + 1)) begin
                build_line();
                send_line();
            end

            // Pause the sender until every expected result has come
            @(negedge i_clk);
            i_valid = 1'b0;
            wait (pending == 0);
        end

        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            if (pending != 0)
                $display("%0d expected results never arrived", pending);
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### shell_command_lexer_top.f
+incdir+design
design/scl_pkg.sv
design/shell_command_lexer_top.sv
bench/shell_command_lexer_checker.sv
bench/shell_command_lexer_top_tb.sv
